FILE: rtl/page_framebuffer_pixel_engine_defines.svh
// Assertion macros shared by the pixel engine checker.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PFPE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel engine check failed");

// Next-cycle implication, disabled while in reset.
`define PFPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel engine check failed");

`endif

FILE: rtl/pfpe_pkg.sv
// Shared constants for the page framebuffer pixel engine.
// No dependencies; used by the top level.
`default_nettype none

package pfpe_pkg;

    localparam int WIDTH_PIXELS  = 128;
    localparam int PAGE_COUNT    = 8;
    localparam int STORE_DEPTH   = WIDTH_PIXELS * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int BYTE_W        = 8;
    // 8-bit column plus 5-bit page index times the row length
    localparam int LIN_W         = 14;

    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_COLUMN = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/page_framebuffer_pixel_engine.sv
// Page framebuffer pixel engine: 128x64 monochrome image in 8 pages of column bytes.
// Depends on pfpe_pkg and pfpe_ram.
//
// Commands are taken when start is high and busy is low; each one gives a single
// result on done/read_data for exactly one cycle, which the receiver cannot stall.
// A pixel plot or a byte read does one frame RAM read, then the write-back or
// result. A column plot does the same when y is a multiple of 8, and adds a second
// write-back when it straddles two pages, since each page byte is one
// read-modify-write on the single frame RAM write port. A fill writes one byte per
// cycle over all STORE_DEPTH = 1024 bytes. After reset the block runs a clearing
// pass over the whole frame RAM with busy high before the first item.
`default_nettype none

module page_framebuffer_pixel_engine
    import pfpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  x,
    input  wire logic [7:0]  y,
    input  wire logic [7:0]  bits,
    input  wire logic [2:0]  page,
    output logic             done,
    output logic      [7:0]  read_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD1  = 2'd2;
    localparam logic [1:0] S_MOD2  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [BYTE_W-1:0] sweep_val_reg, sweep_val_next;
    logic              report_reg, report_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [BYTE_W-1:0] bits_reg, bits_next;
    logic [2:0]        shift_reg, shift_next;
    logic [ADDR_W-1:0] addr1_reg, addr1_next;
    logic [ADDR_W-1:0] addr2_reg, addr2_next;
    logic              ok1_reg, ok1_next;
    logic              ok2_reg, ok2_next;
    logic              done_reg, done_next;
    logic [BYTE_W-1:0] read_data_reg, read_data_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic [4:0]        page_sel;
    logic [4:0]        page2;
    logic              x_ok;
    logic              in_ok;
    logic              col_ok2;
    logic [LIN_W-1:0]  lin1;
    logic [LIN_W-1:0]  lin2;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] col_addr2;

    logic [BYTE_W-1:0] low_mask;
    logic [BYTE_W-1:0] pixel_mask;
    logic [BYTE_W-1:0] pixel_byte;
    logic [BYTE_W-1:0] col_hi_byte;
    logic [BYTE_W-1:0] col_lo_byte;

    pfpe_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (STORE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address decode of the incoming item; the second page wraps like the 8-bit row sum.
    always_comb
    begin
        page_sel  = (cmd == CMD_READ) ? {2'b00, page} : y[7:3];
        page2     = y[7:3] + 5'd1;
        x_ok      = int'(x) < WIDTH_PIXELS;
        in_ok     = x_ok && (int'(page_sel) < PAGE_COUNT);
        col_ok2   = x_ok && (int'(page2) < PAGE_COUNT);
        lin1      = LIN_W'(x) + LIN_W'(page_sel) * LIN_W'(WIDTH_PIXELS);
        lin2      = LIN_W'(x) + LIN_W'(page2) * LIN_W'(WIDTH_PIXELS);
        in_addr   = in_ok ? lin1[ADDR_W-1:0] : '0;
        col_addr2 = col_ok2 ? lin2[ADDR_W-1:0] : '0;
    end

    // Byte merges for the write-back.
    always_comb
    begin
        low_mask    = ~(8'hFF << shift_reg);
        pixel_mask  = 8'd1 << shift_reg;
        pixel_byte  = (bits_reg != 8'd0) ? (ram_rdata | pixel_mask)
                                         : (ram_rdata & ~pixel_mask);
        col_hi_byte = (ram_rdata & low_mask) | (bits_reg << shift_reg);
        col_lo_byte = (ram_rdata & ~low_mask) | (bits_reg >> (4'd8 - {1'b0, shift_reg}));
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        sweep_val_next = sweep_val_reg;
        report_next    = report_reg;
        cmd_next       = cmd_reg;
        bits_next      = bits_reg;
        shift_next     = shift_reg;
        addr1_next     = addr1_reg;
        addr2_next     = addr2_reg;
        ok1_next       = ok1_reg;
        ok2_next       = ok2_reg;
        done_next      = 1'b0;
        read_data_next = '0;

        ram_we    = 1'b0;
        ram_waddr = addr1_reg;
        ram_wdata = pixel_byte;
        ram_raddr = addr2_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = sweep_val_reg;
                if (sweep_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = report_reg;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                ram_raddr = in_addr;
                if (start)
                begin
                    cmd_next   = cmd;
                    bits_next  = bits;
                    shift_next = y[2:0];
                    addr1_next = in_addr;
                    ok1_next   = in_ok;
                    addr2_next = col_addr2;
                    ok2_next   = col_ok2;
                    if (cmd == CMD_FILL)
                    begin
                        state_next     = S_CLEAR;
                        sweep_cnt_next = '0;
                        sweep_val_next = bits;
                        report_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MOD1;
                    end
                end
            end
            S_MOD1:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    read_data_next = ok1_reg ? ram_rdata : '0;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ram_we    = ok1_reg;
                    ram_wdata = (cmd_reg == CMD_PIXEL) ? pixel_byte : col_hi_byte;
                    // Straddling column: second page read goes out this cycle.
                    if (cmd_reg == CMD_COLUMN && shift_reg != 3'd0)
                    begin
                        state_next = S_MOD2;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_MOD2:
            begin
                ram_we     = ok2_reg;
                ram_waddr  = addr2_reg;
                ram_wdata  = col_lo_byte;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_cnt_reg <= '0;
            sweep_val_reg <= '0;
            report_reg    <= 1'b0;
            done_reg      <= 1'b0;
            read_data_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            sweep_val_reg <= sweep_val_next;
            report_reg    <= report_next;
            done_reg      <= done_next;
            read_data_reg <= read_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        bits_reg  <= bits_next;
        shift_reg <= shift_next;
        addr1_reg <= addr1_next;
        addr2_reg <= addr2_next;
        ok1_reg   <= ok1_next;
        ok2_reg   <= ok2_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

FILE: rtl/pfpe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pfpe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [DATA_W-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [DATA_W-1:0]         rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/pfpe_checker.sv
// Port-level checks for the page framebuffer pixel engine, bound to the top level.
// Depends on page_framebuffer_pixel_engine_defines.svh.
`default_nettype none

`include "page_framebuffer_pixel_engine_defines.svh"

module pfpe_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [7:0]  read_data
);

    // A result is only shown once the engine has gone idle.
    `PFPE_ASSERT_NOW(a_done_idle, done, !busy)

    // An accepted item always makes the engine busy in the next cycle.
    `PFPE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // Results never come back to back.
    `PFPE_ASSERT_NEXT(a_done_single, done, !done)

    // Read data is zero outside a result cycle.
    `PFPE_ASSERT_NOW(a_data_quiet, !done, read_data == 8'd0)

endmodule

bind page_framebuffer_pixel_engine pfpe_checker u_pfpe_checker (.*);

`default_nettype wire
